// File: rtl/sbi_pkg.sv
// Shared types and constants for the segment / box intersection pipeline.
package sbi_pkg;

    // Edge codes reported in hit_side
    localparam logic [2:0] SIDE_NONE   = 3'd0;
    localparam logic [2:0] SIDE_TOP    = 3'd1;
    localparam logic [2:0] SIDE_RIGHT  = 3'd2;
    localparam logic [2:0] SIDE_BOTTOM = 3'd3;
    localparam logic [2:0] SIDE_LEFT   = 3'd4;

    localparam int NUM_EDGES     = 4;
    localparam int DIV_STAGES    = 8;   // quotient bits per stage = 32 / DIV_STAGES
    localparam int DIV_BITS      = 4;
    localparam int SEL_STAGES    = 8;   // multiply + compare per edge

    // Input word
    typedef struct packed {
        logic signed [31:0] seg_begin_x;
        logic signed [31:0] seg_begin_y;
        logic signed [31:0] seg_end_x;
        logic signed [31:0] seg_end_y;
        logic signed [31:0] box_x;
        logic signed [31:0] box_y;
        logic        [30:0] box_width;
        logic        [30:0] box_height;
    } sbi_req_t;

    // Output word
    typedef struct packed {
        logic               hit;
        logic signed [31:0] hit_x;
        logic signed [31:0] hit_y;
        logic        [2:0]  hit_side;
    } sbi_rsp_t;

    // Values shared by all edges, carried down the pipe
    typedef struct packed {
        logic [31:0] ex;
        logic [31:0] ey;
        logic [31:0] lx0;
        logic [31:0] ly0;
        logic [31:0] lx1;
        logic [31:0] ly1;
    } sbi_cmn_t;

    // Per-edge setup after differences
    typedef struct packed {
        logic signed [33:0] d;
        logic signed [32:0] rp;
        logic signed [32:0] rq;
        logic signed [31:0] bq;
        logic signed [33:0] lo_rel;
        logic signed [33:0] hi_rel;
        logic               nz;
    } sbi_e3_t;

    // Per-edge setup after sign folding
    typedef struct packed {
        logic               ok;
        logic signed [34:0] d;
        logic        [31:0] rp;
        logic        [31:0] mag;
        logic               neg;
        logic signed [31:0] bq;
        logic signed [33:0] lo_rel;
        logic signed [33:0] hi_rel;
    } sbi_e4_t;

    // Per-edge divider state
    typedef struct packed {
        logic               ok;
        logic        [31:0] rem;
        logic        [31:0] mlo;
        logic        [31:0] q;
        logic        [31:0] rp;
        logic        [31:0] tn;
        logic               neg;
        logic signed [31:0] bq;
        logic signed [33:0] lo_rel;
        logic signed [33:0] hi_rel;
    } sbi_dv_t;

    // Per-edge hit candidate
    typedef struct packed {
        logic        hit;
        logic [31:0] tn;
        logic [31:0] td;
        logic [31:0] px;
        logic [31:0] py;
    } sbi_cd_t;

    // Running nearest-hit selection
    typedef struct packed {
        logic        any;
        logic [31:0] bn;
        logic [31:0] bd;
        logic [31:0] px;
        logic [31:0] py;
        logic [2:0]  side;
    } sbi_sel_t;

endpackage

// File: rtl/segment_box_intersect.sv
// Segment versus axis-aligned box intersection, fully pipelined.
// Throughput: one word per cycle unless the output word is held; four 8-stage dividers
// (4 quotient bits per stage) and the 8-stage nearest-hit chain all run one word per cycle.
// A stalled output freezes the whole pipe; nothing is lost or repeated.
// Reset (rst_n low, async) clears all valid bits; payload registers are not reset.
module segment_box_intersect
    import sbi_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_stall,
    input  sbi_req_t req_word,
    output logic     rsp_valid,
    input  logic     rsp_stall,
    output sbi_rsp_t rsp_word
);

    // Global advance: pipe moves unless the output word is held
    logic adv;
    assign adv       = !(rsp_valid && rsp_stall);
    assign req_stall = !adv;

    // ---------------- stage 1: input register ----------------
    logic     s1_v_reg;
    sbi_req_t s1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_v_reg <= 1'b0;
        else if (adv)
            s1_v_reg <= req_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            s1_reg <= req_word;
    end

    // ---------------- stage 2: deltas and far corner ----------------
    logic               s2_v_reg;
    logic signed [31:0] s2_bx_reg, s2_by_reg, s2_x0_reg, s2_y0_reg;
    logic signed [32:0] s2_x1_reg, s2_y1_reg, s2_rx_reg, s2_ry_reg;
    logic               s2_wnz_reg, s2_hnz_reg;
    sbi_cmn_t           s2_cm_reg;
    logic signed [32:0] s2_x1_next, s2_y1_next;

    always_comb
    begin
        s2_x1_next = {s1_reg.box_x[31], s1_reg.box_x} + {2'b00, s1_reg.box_width};
        s2_y1_next = {s1_reg.box_y[31], s1_reg.box_y} + {2'b00, s1_reg.box_height};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_v_reg <= 1'b0;
        else if (adv)
            s2_v_reg <= s1_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_bx_reg  <= s1_reg.seg_begin_x;
            s2_by_reg  <= s1_reg.seg_begin_y;
            s2_x0_reg  <= s1_reg.box_x;
            s2_y0_reg  <= s1_reg.box_y;
            s2_x1_reg  <= s2_x1_next;
            s2_y1_reg  <= s2_y1_next;
            s2_rx_reg  <= {s1_reg.seg_end_x[31], s1_reg.seg_end_x}
                          - {s1_reg.seg_begin_x[31], s1_reg.seg_begin_x};
            s2_ry_reg  <= {s1_reg.seg_end_y[31], s1_reg.seg_end_y}
                          - {s1_reg.seg_begin_y[31], s1_reg.seg_begin_y};
            s2_wnz_reg <= (s1_reg.box_width != 31'd0);
            s2_hnz_reg <= (s1_reg.box_height != 31'd0);
            s2_cm_reg.ex  <= s1_reg.seg_end_x;
            s2_cm_reg.ey  <= s1_reg.seg_end_y;
            s2_cm_reg.lx0 <= s1_reg.box_x;
            s2_cm_reg.ly0 <= s1_reg.box_y;
            s2_cm_reg.lx1 <= s2_x1_next[31:0];
            s2_cm_reg.ly1 <= s2_y1_next[31:0];
        end
    end

    // ---------------- stage 3: per-edge offsets ----------------
    logic     s3_v_reg;
    sbi_cmn_t s3_cm_reg;
    sbi_e3_t  s3_reg  [NUM_EDGES];
    sbi_e3_t  s3_next [NUM_EDGES];

    always_comb
    begin
        logic               horiz;
        logic signed [32:0] line, bp, lo, hi;
        for (int e = 0; e < NUM_EDGES; e++)
        begin
            horiz = (e % 2) == 0;
            case (e)
                0:       line = {s2_y0_reg[31], s2_y0_reg};
                1:       line = s2_x1_reg;
                2:       line = s2_y1_reg;
                default: line = {s2_x0_reg[31], s2_x0_reg};
            endcase
            bp = horiz ? {s2_by_reg[31], s2_by_reg} : {s2_bx_reg[31], s2_bx_reg};
            lo = horiz ? {s2_x0_reg[31], s2_x0_reg} : {s2_y0_reg[31], s2_y0_reg};
            hi = horiz ? s2_x1_reg : s2_y1_reg;
            s3_next[e].bq     = horiz ? s2_bx_reg : s2_by_reg;
            s3_next[e].rp     = horiz ? s2_ry_reg : s2_rx_reg;
            s3_next[e].rq     = horiz ? s2_rx_reg : s2_ry_reg;
            s3_next[e].nz     = horiz ? s2_wnz_reg : s2_hnz_reg;
            s3_next[e].d      = {line[32], line} - {bp[32], bp};
            s3_next[e].lo_rel = {lo[32], lo} - {{2{s3_next[e].bq[31]}}, s3_next[e].bq};
            s3_next[e].hi_rel = {hi[32], hi} - {{2{s3_next[e].bq[31]}}, s3_next[e].bq};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_v_reg <= 1'b0;
        else if (adv)
            s3_v_reg <= s2_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s3_cm_reg <= s2_cm_reg;
            for (int e = 0; e < NUM_EDGES; e++)
                s3_reg[e] <= s3_next[e];
        end
    end

    // ---------------- stage 4: fold signs ----------------
    logic     s4_v_reg;
    sbi_cmn_t s4_cm_reg;
    sbi_e4_t  s4_reg  [NUM_EDGES];
    sbi_e4_t  s4_next [NUM_EDGES];

    always_comb
    begin
        logic signed [32:0] rp_neg, rq_neg;
        for (int e = 0; e < NUM_EDGES; e++)
        begin
            rp_neg = -s3_reg[e].rp;
            rq_neg = -s3_reg[e].rq;
            s4_next[e].ok     = s3_reg[e].nz && (s3_reg[e].rp != 33'sd0);
            s4_next[e].rp     = s3_reg[e].rp[32] ? rp_neg[31:0] : s3_reg[e].rp[31:0];
            s4_next[e].mag    = s3_reg[e].rq[32] ? rq_neg[31:0] : s3_reg[e].rq[31:0];
            s4_next[e].neg    = s3_reg[e].rq[32];
            s4_next[e].d      = s3_reg[e].rp[32] ? -{s3_reg[e].d[33], s3_reg[e].d}
                                                 :  {s3_reg[e].d[33], s3_reg[e].d};
            s4_next[e].bq     = s3_reg[e].bq;
            s4_next[e].lo_rel = s3_reg[e].lo_rel;
            s4_next[e].hi_rel = s3_reg[e].hi_rel;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s4_v_reg <= 1'b0;
        else if (adv)
            s4_v_reg <= s3_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s4_cm_reg <= s3_cm_reg;
            for (int e = 0; e < NUM_EDGES; e++)
                s4_reg[e] <= s4_next[e];
        end
    end

    // ---------------- stage 5: range check and d*|rq| ----------------
    logic     dv_v_reg  [DIV_STAGES+1];
    sbi_cmn_t dv_cm_reg [DIV_STAGES+1];
    sbi_dv_t  dv_reg    [DIV_STAGES+1][NUM_EDGES];
    sbi_dv_t  dv0_next  [NUM_EDGES];

    always_comb
    begin
        logic [63:0] m;
        for (int e = 0; e < NUM_EDGES; e++)
        begin
            m = s4_reg[e].d[31:0] * s4_reg[e].mag;
            dv0_next[e].ok     = s4_reg[e].ok && !s4_reg[e].d[34]
                                 && (s4_reg[e].d <= $signed({3'b000, s4_reg[e].rp}));
            dv0_next[e].rem    = m[63:32];
            dv0_next[e].mlo    = m[31:0];
            dv0_next[e].q      = 32'd0;
            dv0_next[e].rp     = s4_reg[e].rp;
            dv0_next[e].tn     = s4_reg[e].d[31:0];
            dv0_next[e].neg    = s4_reg[e].neg;
            dv0_next[e].bq     = s4_reg[e].bq;
            dv0_next[e].lo_rel = s4_reg[e].lo_rel;
            dv0_next[e].hi_rel = s4_reg[e].hi_rel;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dv_v_reg[0] <= 1'b0;
        else if (adv)
            dv_v_reg[0] <= s4_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dv_cm_reg[0] <= s4_cm_reg;
            for (int e = 0; e < NUM_EDGES; e++)
                dv_reg[0][e] <= dv0_next[e];
        end
    end

    // ---------------- divider: restoring, DIV_BITS quotient bits per stage ----------------
    for (genvar k = 0; k < DIV_STAGES; k++)
    begin : g_div
        sbi_dv_t dv_next [NUM_EDGES];

        always_comb
        begin
            logic [32:0] t;
            for (int e = 0; e < NUM_EDGES; e++)
            begin
                dv_next[e] = dv_reg[k][e];
                for (int b = 0; b < DIV_BITS; b++)
                begin
                    t = {dv_next[e].rem, dv_next[e].mlo[31]};
                    dv_next[e].mlo = {dv_next[e].mlo[30:0], 1'b0};
                    if (t >= {1'b0, dv_next[e].rp})
                    begin
                        t = t - {1'b0, dv_next[e].rp};
                        dv_next[e].q = {dv_next[e].q[30:0], 1'b1};
                    end
                    else
                    begin
                        dv_next[e].q = {dv_next[e].q[30:0], 1'b0};
                    end
                    dv_next[e].rem = t[31:0];
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dv_v_reg[k+1] <= 1'b0;
            else if (adv)
                dv_v_reg[k+1] <= dv_v_reg[k];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dv_cm_reg[k+1] <= dv_cm_reg[k];
                for (int e = 0; e < NUM_EDGES; e++)
                    dv_reg[k+1][e] <= dv_next[e];
            end
        end
    end

    // ---------------- candidate stage: along-axis range and hit point ----------------
    logic     sl_v_reg  [SEL_STAGES+1];
    sbi_cd_t  cd_reg    [SEL_STAGES+1][NUM_EDGES];
    sbi_sel_t sl_reg    [SEL_STAGES+1];
    sbi_cd_t  cd0_next  [NUM_EDGES];

    always_comb
    begin
        logic signed [34:0] qx, fl, ce, off;
        logic        [31:0] pq, line;
        sbi_dv_t            dv;
        for (int e = 0; e < NUM_EDGES; e++)
        begin
            dv = dv_reg[DIV_STAGES][e];
            qx = $signed({3'b000, dv.q});
            if (!dv.neg)
            begin
                fl  = qx;
                ce  = qx + $signed({34'd0, (dv.rem != 32'd0)});
                off = qx;
            end
            else
            begin
                fl  = -(qx + $signed({34'd0, (dv.rem != 32'd0)}));
                ce  = -qx;
                off = -qx;
            end
            pq = dv.bq + off[31:0];
            case (e)
                0:       line = dv_cm_reg[DIV_STAGES].ly0;
                1:       line = dv_cm_reg[DIV_STAGES].lx1;
                2:       line = dv_cm_reg[DIV_STAGES].ly1;
                default: line = dv_cm_reg[DIV_STAGES].lx0;
            endcase
            cd0_next[e].hit = dv.ok && !(fl < $signed({dv.lo_rel[33], dv.lo_rel}))
                              && !(ce > $signed({dv.hi_rel[33], dv.hi_rel}));
            cd0_next[e].tn  = dv.tn;
            cd0_next[e].td  = dv.rp;
            cd0_next[e].px  = ((e % 2) == 0) ? pq : line;
            cd0_next[e].py  = ((e % 2) == 0) ? line : pq;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sl_v_reg[0] <= 1'b0;
        else if (adv)
            sl_v_reg[0] <= dv_v_reg[DIV_STAGES];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sl_reg[0].any  <= 1'b0;
            sl_reg[0].bn   <= 32'd1;
            sl_reg[0].bd   <= 32'd1;
            sl_reg[0].px   <= dv_cm_reg[DIV_STAGES].ex;
            sl_reg[0].py   <= dv_cm_reg[DIV_STAGES].ey;
            sl_reg[0].side <= SIDE_NONE;
            for (int e = 0; e < NUM_EDGES; e++)
                cd_reg[0][e] <= cd0_next[e];
        end
    end

    // ---------------- nearest-hit chain: multiply stage, then compare stage per edge ----------------
    logic [63:0] p1_reg [NUM_EDGES];
    logic [63:0] p2_reg [NUM_EDGES];

    for (genvar j = 0; j < SEL_STAGES; j++)
    begin : g_sel
        localparam int EDGE = j / 2;
        sbi_sel_t sl_next;

        always_comb
        begin
            sl_next = sl_reg[j];
            if ((j % 2) == 1 && cd_reg[j][EDGE].hit)
            begin
                sl_next.any = 1'b1;
                if (p1_reg[EDGE] < p2_reg[EDGE])
                begin
                    sl_next.bn   = cd_reg[j][EDGE].tn;
                    sl_next.bd   = cd_reg[j][EDGE].td;
                    sl_next.px   = cd_reg[j][EDGE].px;
                    sl_next.py   = cd_reg[j][EDGE].py;
                    sl_next.side = 3'(EDGE + 1);
                end
            end
        end

        if ((j % 2) == 0)
        begin : g_mul
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    p1_reg[EDGE] <= cd_reg[j][EDGE].tn * sl_reg[j].bd;
                    p2_reg[EDGE] <= sl_reg[j].bn * cd_reg[j][EDGE].td;
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                sl_v_reg[j+1] <= 1'b0;
            else if (adv)
                sl_v_reg[j+1] <= sl_v_reg[j];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                sl_reg[j+1]    <= sl_next;
                for (int e = 0; e < NUM_EDGES; e++)
                    cd_reg[j+1][e] <= cd_reg[j][e];
            end
        end
    end

    // ---------------- output register ----------------
    logic     rsp_valid_reg;
    sbi_rsp_t rsp_reg;
    sbi_rsp_t rsp_next;
    sbi_sel_t sl_last;

    always_comb
    begin
        sl_last = sl_reg[SEL_STAGES];
        if (sl_last.any)
        begin
            rsp_next.hit      = 1'b1;
            rsp_next.hit_x    = sl_last.px;
            rsp_next.hit_y    = sl_last.py;
            rsp_next.hit_side = sl_last.side;
        end
        else
        begin
            rsp_next.hit      = 1'b0;
            rsp_next.hit_x    = 32'sd0;
            rsp_next.hit_y    = 32'sd0;
            rsp_next.hit_side = SIDE_NONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else if (adv)
            rsp_valid_reg <= sl_v_reg[SEL_STAGES];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_word  = rsp_reg;

    // ---------------- assertions ----------------
    // divider leaves a remainder below the divisor for edge 0 whenever that edge is in range
    a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
        (dv_v_reg[DIV_STAGES] && dv_reg[DIV_STAGES][0].ok)
        |-> (dv_reg[DIV_STAGES][0].rem < dv_reg[DIV_STAGES][0].rp))
        else $error("divider remainder not below divisor");

    // a miss reports zero point and no side
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_word.hit)
        |-> (rsp_word.hit_x == 32'sd0 && rsp_word.hit_y == 32'sd0
             && rsp_word.hit_side == SIDE_NONE))
        else $error("miss word carries nonzero fields");

    // side code stays in range
    a_side_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp_word.hit_side <= SIDE_LEFT))
        else $error("side code out of range");

    // input is held back exactly when the output word is held
    a_stall_link: assert property (@(posedge clk) disable iff (!rst_n)
        req_stall == (rsp_valid && rsp_stall))
        else $error("input stall does not follow output hold");

endmodule

// File: dv/tb_top.sv
// Self-checking testbench for the segment / box intersection pipeline.
`timescale 1ns / 100ps

module tb_top;
    import sbi_pkg::*;

    localparam int CLK_PERIOD  = 12;
    localparam int PIPE_DEPTH  = 22;
    localparam int NUM_RANDOM  = 700;
    localparam int CYCLE_LIMIT = 400000;

    logic     clk;
    logic     rst_n;
    logic     req_valid;
    logic     req_stall;
    sbi_req_t req_word;
    logic     rsp_valid;
    logic     rsp_stall;
    sbi_rsp_t rsp_word;

    segment_box_intersect uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_word  (req_word),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_word  (rsp_word)
    );

    // Directed row: a word plus an optional typed-in answer
    typedef struct {
        sbi_req_t word;
        logic     known;
        sbi_rsp_t answer;
    } probe_row_t;

    sbi_rsp_t   pending_hits[$];
    probe_row_t probes[$];
    int         errors;
    int         words_sent;
    int         words_checked;
    int         hit_count;
    int         cycles;
    int         send_idle_pct;
    int         recv_idle_pct;

    // Crossing of one box edge; returns t = tn/td and the along-axis coordinate
    function automatic logic crossing(
        input longint bp, input longint rp, input longint ep,
        input longint bq, input longint rq, input longint lo, input longint hi,
        output longint tn, output longint td, output longint pq);
        longint          gap;
        longint          span;
        longint          mag;
        longint unsigned prod;
        longint unsigned quo;
        longint unsigned rmd;
        longint          lo_q;
        longint          hi_q;
        longint          shift;
        gap  = ep - bp;
        span = rp;
        tn = 0;
        td = 1;
        pq = 0;
        if (rp == 0 || lo == hi)
            return 1'b0;
        if (span < 0)
        begin
            gap  = -gap;
            span = -span;
        end
        if (gap < 0 || gap > span)
            return 1'b0;
        mag  = (rq < 0) ? -rq : rq;
        prod = gap * mag;
        quo  = prod / span;
        rmd  = prod % span;
        if (rq >= 0)
        begin
            lo_q  = quo;
            hi_q  = quo + (rmd != 0);
            shift = quo;
        end
        else
        begin
            lo_q  = -(quo + (rmd != 0));
            hi_q  = -quo;
            shift = -quo;
        end
        if (lo_q < lo - bq || hi_q > hi - bq)
            return 1'b0;
        tn = gap;
        td = span;
        pq = bq + shift;
        return 1'b1;
    endfunction

    // Nearest crossing over all box edges, earlier edge wins ties
    function automatic sbi_rsp_t nearest_hit(input sbi_req_t w);
        sbi_rsp_t        res;
        longint          bx, by, ex, ey, x0, y0, x1, y1, rx, ry;
        longint unsigned best_n, best_d, tn, td;
        longint          q, edge_line;
        longint          px, py;
        logic            any_hit;
        logic            got;
        logic [2:0]      side;
        bx = w.seg_begin_x;
        by = w.seg_begin_y;
        ex = w.seg_end_x;
        ey = w.seg_end_y;
        x0 = w.box_x;
        y0 = w.box_y;
        x1 = x0 + longint'(w.box_width);
        y1 = y0 + longint'(w.box_height);
        rx = ex - bx;
        ry = ey - by;
        best_n  = 1;
        best_d  = 1;
        px      = ex;
        py      = ey;
        side    = SIDE_NONE;
        any_hit = 1'b0;
        for (int e = 0; e < NUM_EDGES; e++)
        begin
            case (e)
                0: edge_line = y0;
                1: edge_line = x1;
                2: edge_line = y1;
                default: edge_line = x0;
            endcase
            if (e == 0 || e == 2)
                got = crossing(by, ry, edge_line, bx, rx, x0, x1, tn, td, q);
            else
                got = crossing(bx, rx, edge_line, by, ry, y0, y1, tn, td, q);
            if (got)
            begin
                any_hit = 1'b1;
                if (tn * best_d < best_n * td)
                begin
                    best_n = tn;
                    best_d = td;
                    case (e)
                        0: side = SIDE_TOP;
                        1: side = SIDE_RIGHT;
                        2: side = SIDE_BOTTOM;
                        default: side = SIDE_LEFT;
                    endcase
                    if (e == 0 || e == 2)
                    begin
                        px = q;
                        py = edge_line;
                    end
                    else
                    begin
                        px = edge_line;
                        py = q;
                    end
                end
            end
        end
        res.hit      = any_hit;
        res.hit_x    = any_hit ? px[31:0] : '0;
        res.hit_y    = any_hit ? py[31:0] : '0;
        res.hit_side = any_hit ? side : SIDE_NONE;
        return res;
    endfunction

    function automatic sbi_req_t make_word(
        input int sbx, input int sby, input int sex, input int sey,
        input int bxc, input int byc, input logic [30:0] bw, input logic [30:0] bh);
        sbi_req_t w;
        w.seg_begin_x = sbx;
        w.seg_begin_y = sby;
        w.seg_end_x   = sex;
        w.seg_end_y   = sey;
        w.box_x       = bxc;
        w.box_y       = byc;
        w.box_width   = bw;
        w.box_height  = bh;
        return w;
    endfunction

    function automatic sbi_rsp_t make_answer(
        input logic h, input int ax, input int ay, input logic [2:0] s);
        sbi_rsp_t r;
        r.hit      = h;
        r.hit_x    = ax;
        r.hit_y    = ay;
        r.hit_side = s;
        return r;
    endfunction

    task automatic add_probe(input sbi_req_t w, input logic known, input sbi_rsp_t a);
        probe_row_t row;
        row.word   = w;
        row.known  = known;
        row.answer = a;
        probes.push_back(row);
    endtask

    // Random coordinate: mostly near the box scale, sometimes full range
    function automatic int rand_coord();
        case ($urandom_range(0, 9))
            0, 1: return $urandom;
            2:    return ($urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000);
            default: return int'($urandom_range(0, 32'h0010_0000)) - 32'h0008_0000;
        endcase
    endfunction

    function automatic logic [30:0] rand_size();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return 31'($urandom);
            2:       return 31'h7FFF_FFFF;
            default: return 31'($urandom_range(0, 32'h0008_0000));
        endcase
    endfunction

    // Well-formed case: segment end points within one box size of the box on each side
    function automatic sbi_req_t rand_crossing_word();
        sbi_req_t w;
        int       cx, cy;
        logic [30:0] bw, bh;
        bw = 31'($urandom_range(1, 32'h0004_0000));
        bh = 31'($urandom_range(1, 32'h0004_0000));
        cx = int'($urandom_range(0, 32'h0010_0000)) - 32'h0008_0000;
        cy = int'($urandom_range(0, 32'h0010_0000)) - 32'h0008_0000;
        w.box_x       = cx;
        w.box_y       = cy;
        w.box_width   = bw;
        w.box_height  = bh;
        w.seg_begin_x = cx + int'($urandom_range(0, 3 * bw)) - int'(bw);
        w.seg_begin_y = cy + int'($urandom_range(0, 3 * bh)) - int'(bh);
        w.seg_end_x   = cx + int'($urandom_range(0, 3 * bw)) - int'(bw);
        w.seg_end_y   = cy + int'($urandom_range(0, 3 * bh)) - int'(bh);
        // snap an endpoint onto a box edge now and then
        if ($urandom_range(0, 3) == 0)
            w.seg_end_y = cy;
        if ($urandom_range(0, 5) == 0)
            w.seg_begin_x = cx + int'(bw);
        return w;
    endfunction

    function automatic sbi_req_t rand_noise_word();
        return make_word(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                         rand_coord(), rand_coord(), rand_size(), rand_size());
    endfunction

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Watchdog
    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // Result checker: compare each accepted word with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (pending_hits.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result word %p", $time, rsp_word);
            end
            else
            begin
                sbi_rsp_t exp_w;
                exp_w = pending_hits.pop_front();
                words_checked++;
                if (rsp_word.hit)
                    hit_count++;
                if (rsp_word.hit !== exp_w.hit)
                begin
                    errors++;
                    $display("%0t: hit expected %0b got %0b", $time, exp_w.hit, rsp_word.hit);
                end
                if (rsp_word.hit_x !== exp_w.hit_x)
                begin
                    errors++;
                    $display("%0t: hit_x expected %h got %h", $time, exp_w.hit_x,
                             rsp_word.hit_x);
                end
                if (rsp_word.hit_y !== exp_w.hit_y)
                begin
                    errors++;
                    $display("%0t: hit_y expected %h got %h", $time, exp_w.hit_y,
                             rsp_word.hit_y);
                end
                if (rsp_word.hit_side !== exp_w.hit_side)
                begin
                    errors++;
                    $display("%0t: hit_side expected %0d got %0d", $time,
                             exp_w.hit_side, rsp_word.hit_side);
                end
            end
        end
    end

    // Receiver back-pressure, changed at the falling edge
    always @(negedge clk)
    begin
        if (!rst_n)
            rsp_stall <= 1'b0;
        else
            rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end

    // Send one word; record the expectation once it is taken
    task automatic send_word(input sbi_req_t w, input logic known, input sbi_rsp_t a);
        sbi_rsp_t exp_w;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        req_word  <= w;
        exp_w = nearest_hit(w);
        if (known && exp_w !== a)
        begin
            errors++;
            $display("%0t: table answer %p disagrees with predictor %p", $time, a, exp_w);
        end
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        pending_hits.push_back(known ? a : exp_w);
        words_sent++;
        @(negedge clk);
    endtask

    initial
    begin
        sbi_rsp_t none;
        int       phase_len;
        errors        = 0;
        words_sent    = 0;
        words_checked = 0;
        hit_count     = 0;
        send_idle_pct = 22;
        recv_idle_pct = 64;
        rst_n     = 1'b0;
        req_valid = 1'b0;
        req_word  = '0;
        rsp_stall = 1'b0;
        none = make_answer(1'b0, 0, 0, SIDE_NONE);

        // Directed table; answers typed only where obvious
        add_probe(make_word(0, 0, 0, 0, 0, 0, 0, 0), 1'b1, none);
        // horizontal segment through a unit box: crosses left edge first
        add_probe(make_word(-32'h0001_0000, 32'h8000, 32'h0002_0000, 32'h8000,
                            0, 0, 31'h1_0000, 31'h1_0000), 1'b1,
                  make_answer(1'b1, 0, 32'h8000, SIDE_LEFT));
        // vertical down through the top edge
        add_probe(make_word(32'h8000, -32'h0001_0000, 32'h8000, 32'h0002_0000,
                            0, 0, 31'h1_0000, 31'h1_0000), 1'b1,
                  make_answer(1'b1, 32'h8000, 0, SIDE_TOP));
        // ends exactly on the top edge: only t=1 hit
        add_probe(make_word(32'h8000, -32'h0001_0000, 32'h8000, 0,
                            0, 0, 31'h1_0000, 31'h1_0000), 1'b1,
                  make_answer(1'b1, 32'h8000, 0, SIDE_NONE));
        // zero-length segment on an edge
        add_probe(make_word(32'h8000, 0, 32'h8000, 0, 0, 0, 31'h1_0000, 31'h1_0000),
                  1'b1, none);
        // collinear with the top edge
        add_probe(make_word(-32'h0001_0000, 0, 32'h0002_0000, 0,
                            0, 0, 31'h1_0000, 31'h1_0000), 1'b0, none);
        // zero-width box
        add_probe(make_word(-32'h0001_0000, 32'h8000, 32'h0002_0000, 32'h8000,
                            0, 0, 0, 31'h1_0000), 1'b0, none);
        // corner hit: diagonal through (0,0), top and left tie
        add_probe(make_word(-32'h0001_0000, -32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
                            0, 0, 31'h1_0000, 31'h1_0000), 1'b1,
                  make_answer(1'b1, 0, 0, SIDE_TOP));
        // starts inside, exits right
        add_probe(make_word(32'h8000, 32'h8000, 32'h0003_0000, 32'h8000,
                            0, 0, 31'h1_0000, 31'h1_0000), 1'b1,
                  make_answer(1'b1, 32'h0001_0000, 32'h8000, SIDE_RIGHT));
        // exits bottom
        add_probe(make_word(32'h8000, 32'h8000, 32'h8000, 32'h0003_0000,
                            0, 0, 31'h1_0000, 31'h1_0000), 1'b1,
                  make_answer(1'b1, 32'h8000, 32'h0001_0000, SIDE_BOTTOM));
        // extreme segment across a huge box whose far edges pass 32 bits
        add_probe(make_word(32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                            32'sh7FFF_0000, 32'sh7FFF_0000, 31'h7FFF_FFFF, 31'h7FFF_FFFF),
                  1'b0, none);
        add_probe(make_word(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF,
                            32'sh8000_0000, 32'sh8000_0000, 31'h7FFF_FFFF, 31'h7FFF_FFFF),
                  1'b0, none);
        add_probe(make_word(32'sh8000_0000, 0, 32'sh7FFF_FFFF, 1,
                            -5, -5, 31'h7FFF_FFFF, 31'h7FFF_FFFF), 1'b0, none);
        add_probe(make_word(-1, -1, -1, -1, -1, -1, 31'h7FFF_FFFF, 31'h7FFF_FFFF),
                  1'b0, none);
        // odd slope, truncation on negative direction
        add_probe(make_word(32'h0000_0003, -32'h0000_0007, -32'h0000_0005, 32'h0000_0009,
                            -32'h0000_0004, 0, 31'h9, 31'h4), 1'b0, none);
        // box entirely missed
        add_probe(make_word(32'h0005_0000, 32'h0005_0000, 32'h0006_0000, 32'h0007_0000,
                            0, 0, 31'h1_0000, 31'h1_0000), 1'b1, none);

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (probes[i])
            send_word(probes[i].word, probes[i].known, probes[i].answer);

        // Random part, three idling phases
        phase_len = NUM_RANDOM / 3;
        for (int n = 0; n < NUM_RANDOM; n++)
        begin
            if (n == phase_len)
            begin
                send_idle_pct = 64;
                recv_idle_pct = 22;
            end
            else if (n == 2 * phase_len)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if ($urandom_range(0, 3) != 0)
                send_word(rand_crossing_word(), 1'b0, none);
            else
                send_word(rand_noise_word(), 1'b0, none);
        end
        req_valid <= 1'b0;

        wait (pending_hits.size() == 0);
        repeat (2 * PIPE_DEPTH) @(posedge clk);

        $display("Sent %0d segment/box words, checked %0d results, %0d of them hits.",
                 words_sent, words_checked, hit_count);
        $display("Covered edge ties, end-point-only hits, degenerate boxes and wide spans.");
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// File: filelist.f
rtl/sbi_pkg.sv
rtl/segment_box_intersect.sv
dv/tb_top.sv
